// ===== rtl/fau_pkg.sv =====
// Package for the fraction arithmetic unit: payload structs, codes, constants.
// No dependencies; used by every module in rtl/.
package fau_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int MAG_W = 64;
    localparam int QDEPTH = 2;

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_OVF  = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] num_first;
        logic signed [31:0] den_first;
        logic signed [31:0] num_second;
        logic signed [31:0] den_second;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] num_result;
        logic [30:0]        den_result;
        logic [1:0]         status;
    } out_item_t;

    // Classified work for the back end: raw magnitudes, signs, early verdict.
    typedef struct packed {
        logic [MAG_W-1:0] nm;
        logic [MAG_W-1:0] dm;
        logic             neg;
        logic             done;
        logic [1:0]       status;
    } work_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SHIFT,
        BK_GCD,
        BK_DIVN,
        BK_DIVD,
        BK_OUT
    } bk_state_t;

    function automatic logic signed [OPERAND_WIDTH-1:0] sext_op(input logic [31:0] v);
        sext_op = v[OPERAND_WIDTH-1:0];
    endfunction

endpackage

// ===== rtl/fau_front.sv =====
// Front end: takes input items, forms raw products in a registered pipeline.
// Depends on fau_pkg.
module fau_front (
    input  logic                clk,
    input  logic                rst_n,
    input  fau_pkg::in_item_t   in_data,
    input  logic                in_valid,
    output logic                in_ready,
    output fau_pkg::work_t      wk_data,
    output logic                wk_valid,
    input  logic                wk_ready
);
    import fau_pkg::*;

    localparam int W = OPERAND_WIDTH;

    logic               s1_valid_reg, s1_valid_next;
    logic               s2_valid_reg, s2_valid_next;
    logic [1:0]         func_reg;
    logic [W-1:0]       ma_reg, mb_reg, mc_reg, md_reg;
    logic               sa_reg, sb_reg, sc_reg, sd_reg;
    logic               err_reg;
    logic [2*W-1:0]     p1_reg, p2_reg, pd_reg;
    logic               s1_reg, s2_reg, dneg_reg, err2_reg, sub_reg;

    logic signed [W-1:0] a, b, c, d;
    logic [2*W-1:0]     p1, p2, pd;
    logic               s1, s2, dneg;
    logic [MAG_W-1:0]   nm;
    logic               nneg;
    logic               adv2, adv1;

    function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
        mag = v[W-1] ? W'(-v) : W'(v);
    endfunction

    assign a = sext_op(in_data.num_first);
    assign b = sext_op(in_data.den_first);
    assign c = sext_op(in_data.num_second);
    assign d = sext_op(in_data.den_second);

    assign adv2 = !s2_valid_reg || wk_ready;
    assign adv1 = !s1_valid_reg || adv2;
    assign in_ready = adv1;

    always_comb
    begin
        s1_valid_next = in_valid ? 1'b1 : (adv2 ? 1'b0 : s1_valid_reg);
        s2_valid_next = adv2 ? s1_valid_reg : s2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                s1_valid_reg <= s1_valid_next;
            if (adv2)
                s2_valid_reg <= s2_valid_next;
        end
    end

    // Stage 1: magnitudes and signs of all four operands, and the zero check.
    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            func_reg <= in_data.func;
            err_reg  <= (b == '0) || (d == '0) ||
                        ((in_data.func == FUNC_DIV) && (c == '0));
            ma_reg <= mag(a); sa_reg <= a[W-1];
            mb_reg <= mag(b); sb_reg <= b[W-1];
            mc_reg <= mag(c); sc_reg <= c[W-1];
            md_reg <= mag(d); sd_reg <= d[W-1];
        end
    end

    // Stage 2: three products, with operands and signs chosen by operation.
    always_comb
    begin
        p1   = ma_reg * md_reg;
        s1   = sa_reg ^ sd_reg;
        dneg = sb_reg ^ sd_reg;
        s2   = sc_reg ^ sb_reg;
        p2   = mc_reg * mb_reg;
        pd   = mb_reg * md_reg;
        case (func_reg)
            FUNC_MUL:
            begin
                p1 = ma_reg * mc_reg;
                s1 = sa_reg ^ sc_reg;
            end
            FUNC_DIV:
            begin
                pd   = mb_reg * mc_reg;
                dneg = sb_reg ^ sc_reg;
            end
            FUNC_SUB: s2 = ~(sc_reg ^ sb_reg);
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && s1_valid_reg)
        begin
            p1_reg <= p1; p2_reg <= p2; pd_reg <= pd;
            s1_reg <= s1; s2_reg <= s2; dneg_reg <= dneg;
            err2_reg <= err_reg;
            sub_reg <= (func_reg == FUNC_ADD) || (func_reg == FUNC_SUB);
        end
    end

    // Output: combine cross products for add and subtract.
    always_comb
    begin
        nm   = MAG_W'(p1_reg);
        nneg = s1_reg;
        if (sub_reg)
        begin
            if (s1_reg == s2_reg)
                nm = MAG_W'(p1_reg) + MAG_W'(p2_reg);
            else if (p1_reg >= p2_reg)
                nm = MAG_W'(p1_reg - p2_reg);
            else
            begin
                nm   = MAG_W'(p2_reg - p1_reg);
                nneg = s2_reg;
            end
        end
        wk_data.nm     = nm;
        wk_data.dm     = MAG_W'(pd_reg);
        wk_data.neg    = nneg ^ dneg_reg;
        wk_data.done   = err2_reg || (nm == '0);
        wk_data.status = err2_reg ? ST_ZERO : ST_OK;
    end

    assign wk_valid = s2_valid_reg;

endmodule

// ===== rtl/fau_queue.sv =====
// Short FIFO between front and back ends.
// Depends on fau_pkg.
module fau_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  fau_pkg::work_t  wr_data,
    input  logic            wr_valid,
    output logic            wr_ready,
    output fau_pkg::work_t  rd_data,
    output logic            rd_valid,
    input  logic            rd_ready
);
    import fau_pkg::*;

    localparam int AW = $clog2(QDEPTH);

    work_t           mem [QDEPTH];
    logic [AW-1:0]   wp_reg, rp_reg;
    logic [AW:0]     cnt_reg;
    logic            wr, rd;

    assign wr_ready = cnt_reg != (AW+1)'(QDEPTH);
    assign rd_valid = cnt_reg != '0;
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;
    assign rd_data = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= wp_reg + 1'b1;
            if (rd)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end

endmodule

// ===== rtl/fau_back.sv =====
// Back end: binary GCD, two restoring divisions, range check, result register.
// Depends on fau_pkg.
module fau_back (
    input  logic               clk,
    input  logic               rst_n,
    input  fau_pkg::work_t     wk_data,
    input  logic               wk_valid,
    output logic               wk_ready,
    output fau_pkg::out_item_t out_data,
    output logic               out_valid,
    input  logic               out_ready
);
    import fau_pkg::*;

    localparam int CW = $clog2(MAG_W + 1);
    localparam logic [MAG_W-1:0] LIM = MAG_W'((64'd1 << (OPERAND_WIDTH - 1)) - 1);

    bk_state_t          state_reg, state_next;
    logic [MAG_W-1:0]   nm_reg, dm_reg, ga_reg, gb_reg, q_reg, r_reg;
    logic [MAG_W-1:0]   qn_reg;
    logic [CW-1:0]      k_reg, bit_reg;
    logic               neg_reg;
    out_item_t          res_reg;

    logic [MAG_W-1:0]   g;
    logic [MAG_W:0]     rtry;
    logic [MAG_W-1:0]   dvs, dvd;
    logic [MAG_W-1:0]   nmax;
    logic [MAG_W-1:0]   qfin, rnext;

    assign g    = ga_reg << k_reg;
    assign dvd  = (state_reg == BK_DIVN) ? nm_reg : dm_reg;
    assign dvs  = g;
    assign rtry = {r_reg, dvd[bit_reg[CW-2:0]]} - {1'b0, dvs};
    assign nmax = LIM + MAG_W'(neg_reg);
    assign qfin = {q_reg[MAG_W-2:0], !rtry[MAG_W]};
    assign rnext = rtry[MAG_W] ? {r_reg[MAG_W-2:0], dvd[bit_reg[CW-2:0]]}
                               : rtry[MAG_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
                if (wk_valid)
                    state_next = wk_data.done ? BK_OUT : BK_SHIFT;
            BK_SHIFT:
                if (ga_reg[0] || gb_reg[0])
                    state_next = BK_GCD;
            BK_GCD:
                if (gb_reg == '0)
                    state_next = BK_DIVN;
            BK_DIVN:
                if (bit_reg == '0)
                    state_next = BK_DIVD;
            BK_DIVD:
                if (bit_reg == '0)
                    state_next = BK_OUT;
            BK_OUT:
                if (!out_valid || out_ready)
                    state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BK_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        wk_ready = state_reg == BK_IDLE;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
                if (wk_valid)
                begin
                    nm_reg  <= wk_data.nm;
                    dm_reg  <= wk_data.dm;
                    ga_reg  <= wk_data.nm;
                    gb_reg  <= wk_data.dm;
                    neg_reg <= wk_data.neg;
                    k_reg   <= '0;
                    res_reg.num_result <= '0;
                    res_reg.den_result <= 31'd1;
                    res_reg.status     <= wk_data.status;
                end
            BK_SHIFT:
                if (!(ga_reg[0] || gb_reg[0]))
                begin
                    ga_reg <= ga_reg >> 1;
                    gb_reg <= gb_reg >> 1;
                    k_reg  <= k_reg + 1'b1;
                end
                else
                begin
                    // make a odd before the subtract loop
                    if (!ga_reg[0])
                    begin
                        ga_reg <= gb_reg;
                        gb_reg <= ga_reg;
                    end
                end
            BK_GCD:
                if (gb_reg != '0)
                begin
                    if (!gb_reg[0])
                        gb_reg <= gb_reg >> 1;
                    else if (ga_reg > gb_reg)
                    begin
                        ga_reg <= gb_reg;
                        gb_reg <= ga_reg - gb_reg;
                    end
                    else
                        gb_reg <= gb_reg - ga_reg;
                end
                else
                begin
                    r_reg   <= '0;
                    bit_reg <= CW'(MAG_W - 1);
                end
            BK_DIVN, BK_DIVD:
            begin
                q_reg <= qfin;
                if (bit_reg != '0)
                begin
                    r_reg   <= rnext;
                    bit_reg <= bit_reg - 1'b1;
                end
                else if (state_reg == BK_DIVN)
                begin
                    qn_reg  <= qfin;
                    r_reg   <= '0;
                    bit_reg <= CW'(MAG_W - 1);
                end
                else
                begin
                    // final quotient is the reduced denominator
                    if (qfin > LIM || qn_reg > nmax)
                        res_reg.status <= ST_OVF;
                    else
                    begin
                        res_reg.num_result <= neg_reg ? 32'(-qn_reg) : 32'(qn_reg);
                        res_reg.den_result <= 31'(qfin);
                    end
                end
            end
            default: ;
        endcase
    end

    // Output register: hold until taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (state_reg == BK_OUT && (!out_valid || out_ready))
            out_valid <= 1'b1;
        else if (out_ready)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BK_OUT && (!out_valid || out_ready))
            out_data <= res_reg;
    end

endmodule

// ===== rtl/fraction_arithmetic_unit.sv =====
// Top level of the fraction arithmetic unit: front end, queue, back end.
// Depends on fau_pkg, fau_front, fau_queue, fau_back.
//
//  channel | direction | handshake        | payload
//  in      | input     | in_valid/ready   | fau_pkg::in_item_t
//  out     | output    | out_valid/ready  | fau_pkg::out_item_t
//
// Front end takes an item per cycle, unless stalled by the queue, into a two-stage product pipeline.
// Back end holds one item at a time through the shift step, the binary GCD loop
// and two 64-step restoring divisions, and takes no new item until it is done.
// Error and zero results skip the loops and go straight to the output state.
// Reset clears all control state; a stalled output holds the back end.
module fraction_arithmetic_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  fau_pkg::in_item_t  in_data,
    input  logic               in_valid,
    output logic               in_ready,
    output fau_pkg::out_item_t out_data,
    output logic               out_valid,
    input  logic               out_ready
);
    import fau_pkg::*;

    work_t  f_data, q_data;
    logic   f_valid, f_ready, q_valid, q_ready;

    fau_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_data(in_data), .in_valid(in_valid), .in_ready(in_ready),
        .wk_data(f_data), .wk_valid(f_valid), .wk_ready(f_ready)
    );

    fau_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_data(f_data), .wr_valid(f_valid), .wr_ready(f_ready),
        .rd_data(q_data), .rd_valid(q_valid), .rd_ready(q_ready)
    );

    fau_back u_back (
        .clk(clk), .rst_n(rst_n),
        .wk_data(q_data), .wk_valid(q_valid), .wk_ready(q_ready),
        .out_data(out_data), .out_valid(out_valid), .out_ready(out_ready)
    );

endmodule
